[rtl/wtr_pkg.sv]
// ----------------------------------------------------------------------------
// wtr_pkg
// Shared types, span limits and elaboration-time intensity tables for the
// wavelength to RGB pipeline.
// ----------------------------------------------------------------------------
package wtr_pkg;

    localparam int unsigned WL_W      = 10;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned Q16_W     = 17;
    localparam int unsigned IDX_W     = 7;
    localparam int unsigned LUT_DEPTH = 128;
    localparam int unsigned PROD_W    = 2 * Q16_W;

    localparam int unsigned ONE_Q16   = 65536;

    localparam logic [WL_W-1:0] WL_MIN      = 10'd350;
    localparam logic [WL_W-1:0] WL_B1_END   = 10'd439;
    localparam logic [WL_W-1:0] WL_B2_END   = 10'd489;
    localparam logic [WL_W-1:0] WL_B3_END   = 10'd509;
    localparam logic [WL_W-1:0] WL_B4_END   = 10'd579;
    localparam logic [WL_W-1:0] WL_B5_END   = 10'd644;
    localparam logic [WL_W-1:0] WL_MAX      = 10'd780;
    localparam logic [WL_W-1:0] WL_RISE_END = 10'd419;
    localparam logic [WL_W-1:0] WL_FALL_BEG = 10'd700;

    localparam logic [WL_W-1:0] WL_440      = 10'd440;
    localparam logic [WL_W-1:0] WL_510      = 10'd510;
    localparam logic [WL_W-1:0] WL_645      = 10'd645;
    localparam logic [WL_W-1:0] WL_320      = 10'd320;

    localparam int unsigned DEN_R1   = 90;
    localparam int unsigned DEN_G2   = 50;
    localparam int unsigned DEN_B3   = 20;
    localparam int unsigned DEN_R4   = 70;
    localparam int unsigned DEN_G5   = 65;
    localparam int unsigned DEN_RISE = 100;
    localparam int unsigned DEN_FALL = 800;
    localparam int unsigned FALL_BASE = 240;
    localparam int unsigned FALL_STEP = 7;

    localparam logic [Q16_W-1:0] Q16_ONE  = 17'h10000;
    localparam logic [Q16_W-1:0] Q16_ZERO = 17'h00000;

    typedef logic [Q16_W-1:0] q16_t;
    typedef q16_t lut_t [LUT_DEPTH];

    typedef enum logic [2:0] {
        TAB_R1,
        TAB_G2,
        TAB_B3,
        TAB_R4,
        TAB_G5,
        TAB_RISE,
        TAB_FALL
    } tab_e;

    typedef struct packed {
        q16_t red;
        q16_t green;
        q16_t blue;
        q16_t fade;
    } inten_t;

    // Ratio tables, rounded to nearest with ties up. Entries outside a
    // segment's range are never selected.
    function automatic lut_t lut_build(input tab_e tab);
        lut_t        t;
        int unsigned n;
        int unsigned v;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            n = i;
            case (tab)
                TAB_R1:   v = (n * 2 * ONE_Q16 + DEN_R1) / (2 * DEN_R1);
                TAB_G2:   v = (n * 2 * ONE_Q16 + DEN_G2) / (2 * DEN_G2);
                TAB_B3:   v = (n * 2 * ONE_Q16 + DEN_B3) / (2 * DEN_B3);
                TAB_R4:   v = (n * 2 * ONE_Q16 + DEN_R4) / (2 * DEN_R4);
                TAB_G5:   v = (n * 2 * ONE_Q16 + DEN_G5) / (2 * DEN_G5);
                TAB_RISE: v = (n * 2 * ONE_Q16 + DEN_RISE) / (2 * DEN_RISE);
                TAB_FALL: v = ((FALL_BASE + FALL_STEP * n) * 2 * ONE_Q16 + DEN_FALL)
                              / (2 * DEN_FALL);
                default:  v = 0;
            endcase
            t[i] = v[Q16_W-1:0];
        end
        return t;
    endfunction

endpackage

[rtl/wtr_lookup.sv]
// ----------------------------------------------------------------------------
// wtr_lookup
// Input register, then segment decode and table lookup of raw channel
// intensities and the edge-fade factor.
// ----------------------------------------------------------------------------
module wtr_lookup (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [wtr_pkg::WL_W-1:0]  in_wavelength,
    output logic                      out_valid,
    input  logic                      out_ready,
    output wtr_pkg::inten_t           out_inten
);
    import wtr_pkg::*;

    localparam lut_t R1_LUT   = lut_build(TAB_R1);
    localparam lut_t G2_LUT   = lut_build(TAB_G2);
    localparam lut_t B3_LUT   = lut_build(TAB_B3);
    localparam lut_t R4_LUT   = lut_build(TAB_R4);
    localparam lut_t G5_LUT   = lut_build(TAB_G5);
    localparam lut_t RISE_LUT = lut_build(TAB_RISE);
    localparam lut_t FALL_LUT = lut_build(TAB_FALL);

    logic            vld1_reg;
    logic [WL_W-1:0] wl_reg;
    logic            vld2_reg;
    inten_t          inten_reg;
    inten_t          inten_next;
    logic            ready1;
    logic            ready2;

    logic [WL_W-1:0] d_r1;
    logic [WL_W-1:0] d_g2;
    logic [WL_W-1:0] d_b3;
    logic [WL_W-1:0] d_r4;
    logic [WL_W-1:0] d_g5;
    logic [WL_W-1:0] d_rise;
    logic [WL_W-1:0] d_fall;

    assign ready2   = !vld2_reg || out_ready;
    assign ready1   = !vld1_reg || ready2;
    assign in_ready = ready1;

    assign d_r1   = WL_440 - wl_reg;
    assign d_g2   = wl_reg - WL_440;
    assign d_b3   = WL_510 - wl_reg;
    assign d_r4   = wl_reg - WL_510;
    assign d_g5   = WL_645 - wl_reg;
    assign d_rise = wl_reg - WL_320;
    assign d_fall = WL_MAX - wl_reg;

    always_comb begin
        inten_next = '{red: Q16_ZERO, green: Q16_ZERO, blue: Q16_ZERO, fade: Q16_ZERO};
        if (wl_reg >= WL_MIN && wl_reg <= WL_MAX) begin
            if (wl_reg <= WL_B1_END) begin
                inten_next.red  = R1_LUT[d_r1[IDX_W-1:0]];
                inten_next.blue = Q16_ONE;
            end else if (wl_reg <= WL_B2_END) begin
                inten_next.green = G2_LUT[d_g2[IDX_W-1:0]];
                inten_next.blue  = Q16_ONE;
            end else if (wl_reg <= WL_B3_END) begin
                inten_next.green = Q16_ONE;
                inten_next.blue  = B3_LUT[d_b3[IDX_W-1:0]];
            end else if (wl_reg <= WL_B4_END) begin
                inten_next.red   = R4_LUT[d_r4[IDX_W-1:0]];
                inten_next.green = Q16_ONE;
            end else if (wl_reg <= WL_B5_END) begin
                inten_next.red   = Q16_ONE;
                inten_next.green = G5_LUT[d_g5[IDX_W-1:0]];
            end else begin
                inten_next.red = Q16_ONE;
            end

            if (wl_reg <= WL_RISE_END) begin
                inten_next.fade = RISE_LUT[d_rise[IDX_W-1:0]];
            end else if (wl_reg <= WL_FALL_BEG) begin
                inten_next.fade = Q16_ONE;
            end else begin
                inten_next.fade = FALL_LUT[d_fall[IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                vld1_reg <= in_valid;
            end
            if (ready2) begin
                vld2_reg <= vld1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            wl_reg <= in_wavelength;
        end
        if (ready2 && vld1_reg) begin
            inten_reg <= inten_next;
        end
    end

    assign out_valid = vld2_reg;
    assign out_inten = inten_reg;

endmodule

[rtl/wtr_scale.sv]
// ----------------------------------------------------------------------------
// wtr_scale
// Multiplies each channel intensity by the fade factor, then scales by 255
// and rounds to the 8-bit channel word.
// ----------------------------------------------------------------------------
module wtr_scale (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  wtr_pkg::inten_t           in_inten,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [wtr_pkg::CH_W-1:0]  out_red,
    output logic [wtr_pkg::CH_W-1:0]  out_green,
    output logic [wtr_pkg::CH_W-1:0]  out_blue
);
    import wtr_pkg::*;

    localparam int unsigned SUM_W = PROD_W + CH_W;
    localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'(64'h8000_0000);

    logic              vld3_reg;
    logic [PROD_W-1:0] prod_r_reg;
    logic [PROD_W-1:0] prod_g_reg;
    logic [PROD_W-1:0] prod_b_reg;
    logic              vld4_reg;
    logic [CH_W-1:0]   red_reg;
    logic [CH_W-1:0]   green_reg;
    logic [CH_W-1:0]   blue_reg;
    logic              ready3;
    logic              ready4;

    logic [SUM_W-1:0]  sum_r_next;
    logic [SUM_W-1:0]  sum_g_next;
    logic [SUM_W-1:0]  sum_b_next;

    assign ready4   = !vld4_reg || out_ready;
    assign ready3   = !vld3_reg || ready4;
    assign in_ready = ready3;

    // p * 255 + 2^31, channel word is bits [39:32]
    assign sum_r_next = {prod_r_reg, {CH_W{1'b0}}} - {{CH_W{1'b0}}, prod_r_reg} + HALF_LSB;
    assign sum_g_next = {prod_g_reg, {CH_W{1'b0}}} - {{CH_W{1'b0}}, prod_g_reg} + HALF_LSB;
    assign sum_b_next = {prod_b_reg, {CH_W{1'b0}}} - {{CH_W{1'b0}}, prod_b_reg} + HALF_LSB;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end else begin
            if (ready3) begin
                vld3_reg <= in_valid;
            end
            if (ready4) begin
                vld4_reg <= vld3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready3 && in_valid) begin
            prod_r_reg <= PROD_W'(in_inten.red)   * PROD_W'(in_inten.fade);
            prod_g_reg <= PROD_W'(in_inten.green) * PROD_W'(in_inten.fade);
            prod_b_reg <= PROD_W'(in_inten.blue)  * PROD_W'(in_inten.fade);
        end
        if (ready4 && vld3_reg) begin
            red_reg   <= sum_r_next[39:32];
            green_reg <= sum_g_next[39:32];
            blue_reg  <= sum_b_next[39:32];
        end
    end

    assign out_valid = vld4_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

endmodule

[rtl/wavelength_to_rgb.sv]
// ----------------------------------------------------------------------------
// wavelength_to_rgb
// Maps a whole-nanometre wavelength to an 8-bit RGB color (gamma 1).
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while m_ready does not stall, set by the four-stage register pipeline
// (input, table lookup, 17x17 multiply, scale and round).
// A stall on m_ready holds every stage; bubbles are squeezed out.
// Reset (aresetn low, synchronous) clears all stage valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module wavelength_to_rgb (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [wtr_pkg::WL_W-1:0]    s_wavelength_nm,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [wtr_pkg::CH_W-1:0]    m_red,
    output logic [wtr_pkg::CH_W-1:0]    m_green,
    output logic [wtr_pkg::CH_W-1:0]    m_blue
);
    import wtr_pkg::*;

    logic   lk_valid;
    logic   lk_ready;
    inten_t lk_inten;

    wtr_lookup u_lookup (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_wavelength (s_wavelength_nm),
        .out_valid     (lk_valid),
        .out_ready     (lk_ready),
        .out_inten     (lk_inten)
    );

    wtr_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lk_valid),
        .in_ready  (lk_ready),
        .in_inten  (lk_inten),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_red   (m_red),
        .out_green (m_green),
        .out_blue  (m_blue)
    );

endmodule

[test/wavelength_to_rgb_test.sv]
// ----------------------------------------------------------------------------
// wavelength_to_rgb_test
// Drives wavelengths through the color mapper: corner points of every segment
// and of the fade ramps first, then random words under three idling patterns
// and one long output stall. Each color word is compared with a bit-exact
// fixed-point prediction, oldest first.
// ----------------------------------------------------------------------------
module wavelength_to_rgb_test;

    localparam int unsigned RANDOM_WORDS = 1300;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_AT      = 1050;
    localparam int unsigned HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [wtr_pkg::WL_W-1:0] nm;
        logic [wtr_pkg::CH_W-1:0] red;
        logic [wtr_pkg::CH_W-1:0] green;
        logic [wtr_pkg::CH_W-1:0] blue;
    } color_t;

    class color_scoreboard;
        color_t      expected_colors [$];
        int unsigned mismatches;
        int unsigned colors_checked;

        function new();
            mismatches     = 0;
            colors_checked = 0;
        endfunction

        // round-to-nearest, ties up, Q16
        function longint unsigned q16_div(longint unsigned num, longint unsigned den);
            return (num * 2 * 65536 + den) / (2 * den);
        endfunction

        function logic [wtr_pkg::CH_W-1:0] to_channel(longint unsigned inten,
                                                      longint unsigned fade);
            longint unsigned p;
            p = inten * fade * 255;
            return 8'((p + 64'h8000_0000) >> 32);
        endfunction

        function color_t predict_color(logic [wtr_pkg::WL_W-1:0] nm);
            color_t          c;
            longint unsigned w;
            longint unsigned ri;
            longint unsigned gi;
            longint unsigned bi;
            longint unsigned fade;
            w    = nm;
            ri   = 0;
            gi   = 0;
            bi   = 0;
            fade = 0;
            if (w >= 350 && w <= 780) begin
                if (w <= 439) begin
                    ri = q16_div(440 - w, 90);
                    bi = 65536;
                end else if (w <= 489) begin
                    gi = q16_div(w - 440, 50);
                    bi = 65536;
                end else if (w <= 509) begin
                    gi = 65536;
                    bi = q16_div(510 - w, 20);
                end else if (w <= 579) begin
                    ri = q16_div(w - 510, 70);
                    gi = 65536;
                end else if (w <= 644) begin
                    ri = 65536;
                    gi = q16_div(645 - w, 65);
                end else begin
                    ri = 65536;
                end
                if (w <= 419)
                    fade = q16_div(w - 320, 100);
                else if (w <= 700)
                    fade = 65536;
                else
                    fade = q16_div(240 + 7 * (780 - w), 800);
            end
            c.nm    = nm;
            c.red   = to_channel(ri, fade);
            c.green = to_channel(gi, fade);
            c.blue  = to_channel(bi, fade);
            return c;
        endfunction

        function void note_wavelength(logic [wtr_pkg::WL_W-1:0] nm);
            expected_colors.insert(expected_colors.size(), predict_color(nm));
        endfunction

        task report_mismatch(string what, int unsigned nm, int unsigned got,
                             int unsigned want);
            $display("mismatch %s: wl %0d got %0d want %0d", what, nm, got, want);
            mismatches++;
        endtask

        task check_color(logic [wtr_pkg::CH_W-1:0] red, logic [wtr_pkg::CH_W-1:0] green,
                         logic [wtr_pkg::CH_W-1:0] blue);
            color_t c;
            colors_checked++;
            if (expected_colors.size() == 0) begin
                report_mismatch("unexpected word", 0, 32'({red, green, blue}), 0);
            end else begin
                c = expected_colors.pop_front();
                if (red !== c.red)
                    report_mismatch("red", c.nm, red, c.red);
                if (green !== c.green)
                    report_mismatch("green", c.nm, green, c.green);
                if (blue !== c.blue)
                    report_mismatch("blue", c.nm, blue, c.blue);
            end
        endtask

        function int unsigned pending();
            return expected_colors.size();
        endfunction
    endclass

    logic                     aclk            = 1'b0;
    logic                     aresetn         = 1'b0;
    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic [wtr_pkg::WL_W-1:0] s_wavelength_nm = '0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic [wtr_pkg::CH_W-1:0] m_red;
    logic [wtr_pkg::CH_W-1:0] m_green;
    logic [wtr_pkg::CH_W-1:0] m_blue;

    color_scoreboard board = new();
    int unsigned     src_idle_pct  = 15;
    int unsigned     sink_idle_pct = 72;
    int unsigned     cycle_count   = 0;

    int unsigned corner_nm [25] = '{0, 349, 350, 351, 385, 419, 420, 439, 440, 441,
                                    489, 490, 509, 510, 579, 580, 644, 645, 700, 701,
                                    779, 780, 781, 512, 1023};

    wavelength_to_rgb uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_wavelength_nm (s_wavelength_nm),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task send_word(logic [wtr_pkg::WL_W-1:0] nm);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_wavelength_nm <= nm;
        do @(posedge aclk); while (!s_ready);
        board.note_wavelength(nm);
    endtask

    // output side: check accepted words, then pick ready for the next cycle
    initial begin
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready)
                board.check_color(m_red, m_green, m_blue);
            if (!held && board.colors_checked >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_nm[i])
            send_word(corner_nm[i][wtr_pkg::WL_W-1:0]);

        for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 3) begin
                src_idle_pct  = 72;
                sink_idle_pct = 15;
            end else if (i == 2 * RANDOM_WORDS / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if ($urandom_range(99) < 75)
                send_word(10'($urandom_range(780, 350)));
            else
                send_word(10'($urandom_range(1023, 0)));
        end
        s_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (board.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[wavelength_to_rgb.f]
rtl/wtr_pkg.sv
rtl/wtr_lookup.sv
rtl/wtr_scale.sv
rtl/wavelength_to_rgb.sv
test/wavelength_to_rgb_test.sv
